### hdl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg: shared types, constants and micro-program for the loudness meter
// Item layouts, register map, datapath opcodes and the per-item step table.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int SAMPLE_RATE_DEF = 48000;
   localparam int MAX_BLOCK_DEF   = 4096;
   localparam int TWO_PI_150_Q10  = 965097;

   localparam int N_REGS = 8;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_HP_B0    = 3'd0;
   localparam logic [2:0] REG_HP_A1    = 3'd1;
   localparam logic [2:0] REG_HP_A2    = 3'd2;
   localparam logic [2:0] REG_SHELF_B0 = 3'd3;
   localparam logic [2:0] REG_SHELF_B1 = 3'd4;
   localparam logic [2:0] REG_SHELF_B2 = 3'd5;
   localparam logic [2:0] REG_SHELF_A1 = 3'd6;
   localparam logic [2:0] REG_SHELF_A2 = 3'd7;

   localparam logic [DATA_W-1:0] COEF_ONE = 32'h4000_0000;

   typedef logic [N_REGS-1:0][DATA_W-1:0] coef_bank_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          block_end;
   } req_item_type;

   typedef struct packed {
      logic [58:0]        kweighted_sum;
      logic [58:0]        left_energy;
      logic [58:0]        right_energy;
      logic [58:0]        hp_left_energy;
      logic [58:0]        hp_right_energy;
      logic signed [59:0] hp_cross_sum;
      logic [58:0]        mid_energy;
      logic [58:0]        side_energy;
      logic [23:0]        sample_peak;
      logic [23:0]        true_peak;
      logic [36:0]        transient_sum;
      logic [12:0]        block_samples;
   } rsp_item_type;

   // multiplier operand A sources
   localparam logic [3:0] A_NONE  = 4'd0;
   localparam logic [3:0] A_HB0   = 4'd1;
   localparam logic [3:0] A_HA1   = 4'd2;
   localparam logic [3:0] A_HA2   = 4'd3;
   localparam logic [3:0] A_SB0   = 4'd4;
   localparam logic [3:0] A_SB1   = 4'd5;
   localparam logic [3:0] A_SB2   = 4'd6;
   localparam logic [3:0] A_SA1   = 4'd7;
   localparam logic [3:0] A_SA2   = 4'd8;
   localparam logic [3:0] A_ALPHA = 4'd9;
   localparam logic [3:0] A_X     = 4'd10;
   localparam logic [3:0] A_K     = 4'd11;
   localparam logic [3:0] A_HP    = 4'd12;
   localparam logic [3:0] A_SUM   = 4'd13;
   localparam logic [3:0] A_DIF   = 4'd14;

   // multiplier operand B sources
   localparam logic [2:0] B_X   = 3'd0;
   localparam logic [2:0] B_H   = 3'd1;
   localparam logic [2:0] B_K   = 3'd2;
   localparam logic [2:0] B_OPD = 3'd3;
   localparam logic [2:0] B_HP  = 3'd4;
   localparam logic [2:0] B_HPR = 3'd5;
   localparam logic [2:0] B_SUM = 3'd6;
   localparam logic [2:0] B_DIF = 3'd7;

   // actions on the registered product
   localparam logic [3:0] ACT_NONE = 4'd0;
   localparam logic [3:0] ACT_HY   = 4'd1;
   localparam logic [3:0] ACT_HZ0  = 4'd2;
   localparam logic [3:0] ACT_HZ1  = 4'd3;
   localparam logic [3:0] ACT_KY   = 4'd4;
   localparam logic [3:0] ACT_U    = 4'd5;
   localparam logic [3:0] ACT_V    = 4'd6;
   localparam logic [3:0] ACT_SZ0  = 4'd7;
   localparam logic [3:0] ACT_SZ1  = 4'd8;
   localparam logic [3:0] ACT_OP   = 4'd9;
   localparam logic [3:0] ACT_ACC  = 4'd10;
   localparam logic [3:0] ACT_TP   = 4'd11;
   localparam logic [3:0] ACT_PK   = 4'd12;

   // accumulator select
   localparam logic [2:0] ACC_KW   = 3'd0;
   localparam logic [2:0] ACC_L    = 3'd1;
   localparam logic [2:0] ACC_R    = 3'd2;
   localparam logic [2:0] ACC_HL   = 3'd3;
   localparam logic [2:0] ACC_HR   = 3'd4;
   localparam logic [2:0] ACC_X    = 3'd5;
   localparam logic [2:0] ACC_MID  = 3'd6;
   localparam logic [2:0] ACC_SIDE = 3'd7;

   localparam int N_STEPS = 32;
   localparam int STEP_W  = $clog2(N_STEPS);

   typedef struct packed {
      logic [3:0] a_sel;
      logic [2:0] b_sel;
      logic       mul_ch;
      logic [3:0] act;
      logic       act_ch;
      logic [2:0] acc_idx;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    emit;
      uop_type uop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic block_done;
   } dp_status_type;

   function automatic uop_type mk(input logic [3:0] a, input logic [2:0] b,
                                  input logic mch, input logic [3:0] act,
                                  input logic ach, input logic [2:0] idx);
      uop_type u;
      u.a_sel   = a;
      u.b_sel   = b;
      u.mul_ch  = mch;
      u.act     = act;
      u.act_ch  = ach;
      u.acc_idx = idx;
      return u;
   endfunction

   // at most one multiply issued and one product consumed per step
   function automatic uop_type uop_rom(input logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         5'd0:  u = mk(A_HB0,   B_X,   1'b0, ACT_NONE, 1'b0, ACC_KW);
         5'd1:  u = mk(A_NONE,  B_X,   1'b0, ACT_HY,   1'b0, ACC_KW);
         5'd2:  u = mk(A_HA1,   B_H,   1'b0, ACT_PK,   1'b0, ACC_KW);
         5'd3:  u = mk(A_HA2,   B_H,   1'b0, ACT_HZ0,  1'b0, ACC_KW);
         5'd4:  u = mk(A_SB0,   B_H,   1'b0, ACT_HZ1,  1'b0, ACC_KW);
         5'd5:  u = mk(A_SB1,   B_H,   1'b0, ACT_KY,   1'b0, ACC_KW);
         5'd6:  u = mk(A_SB2,   B_H,   1'b0, ACT_U,    1'b0, ACC_KW);
         5'd7:  u = mk(A_SA1,   B_K,   1'b0, ACT_V,    1'b0, ACC_KW);
         5'd8:  u = mk(A_SA2,   B_K,   1'b0, ACT_SZ0,  1'b0, ACC_KW);
         5'd9:  u = mk(A_HB0,   B_X,   1'b1, ACT_SZ1,  1'b0, ACC_KW);
         5'd10: u = mk(A_NONE,  B_X,   1'b1, ACT_HY,   1'b1, ACC_KW);
         5'd11: u = mk(A_HA1,   B_H,   1'b1, ACT_NONE, 1'b1, ACC_KW);
         5'd12: u = mk(A_HA2,   B_H,   1'b1, ACT_HZ0,  1'b1, ACC_KW);
         5'd13: u = mk(A_SB0,   B_H,   1'b1, ACT_HZ1,  1'b1, ACC_KW);
         5'd14: u = mk(A_SB1,   B_H,   1'b1, ACT_KY,   1'b1, ACC_KW);
         5'd15: u = mk(A_SB2,   B_H,   1'b1, ACT_U,    1'b1, ACC_KW);
         5'd16: u = mk(A_SA1,   B_K,   1'b1, ACT_V,    1'b1, ACC_KW);
         5'd17: u = mk(A_SA2,   B_K,   1'b1, ACT_SZ0,  1'b1, ACC_KW);
         5'd18: u = mk(A_ALPHA, B_OPD, 1'b0, ACT_SZ1,  1'b1, ACC_KW);
         5'd19: u = mk(A_ALPHA, B_OPD, 1'b1, ACT_OP,   1'b0, ACC_KW);
         5'd20: u = mk(A_K,     B_K,   1'b0, ACT_OP,   1'b1, ACC_KW);
         5'd21: u = mk(A_K,     B_K,   1'b1, ACT_ACC,  1'b0, ACC_KW);
         5'd22: u = mk(A_X,     B_X,   1'b0, ACT_ACC,  1'b0, ACC_KW);
         5'd23: u = mk(A_X,     B_X,   1'b1, ACT_ACC,  1'b0, ACC_L);
         5'd24: u = mk(A_HP,    B_HP,  1'b0, ACT_ACC,  1'b0, ACC_R);
         5'd25: u = mk(A_HP,    B_HP,  1'b1, ACT_ACC,  1'b0, ACC_HL);
         5'd26: u = mk(A_HP,    B_HPR, 1'b0, ACT_ACC,  1'b0, ACC_HR);
         5'd27: u = mk(A_SUM,   B_SUM, 1'b0, ACT_ACC,  1'b0, ACC_X);
         5'd28: u = mk(A_DIF,   B_DIF, 1'b0, ACT_ACC,  1'b0, ACC_MID);
         5'd29: u = mk(A_NONE,  B_X,   1'b0, ACT_ACC,  1'b0, ACC_SIDE);
         5'd30: u = mk(A_NONE,  B_X,   1'b0, ACT_TP,   1'b0, ACC_KW);
         5'd31: u = mk(A_NONE,  B_X,   1'b0, ACT_TP,   1'b1, ACC_KW);
         default: u = mk(A_NONE, B_X,  1'b0, ACT_NONE, 1'b0, ACC_KW);
      endcase
      return u;
   endfunction

endpackage

### hdl/slm_csr.sv
// ----------------------------------------------------------------------------
// slm_csr: coefficient register bank
// APB-style write/read of the eight Q2.30 filter coefficients.
// ----------------------------------------------------------------------------
module slm_csr
   import slm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready,
   output coef_bank_type       coef
);

   // hp_b0 (reg 0) and shelf_b0 (reg 3) at 1.0, rest zero: shelf filter passes
   localparam coef_bank_type COEF_RESET =
      {{4{DATA_W'(0)}}, COEF_ONE, {2{DATA_W'(0)}}, COEF_ONE};

   coef_bank_type regs_ff, regs_in;
   logic [2:0]    idx;

   assign idx = csr_paddr[ADDR_W-1:2];

   always_comb begin
      regs_in = regs_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         regs_in[idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= COEF_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = regs_ff[idx];
   assign csr_pready = 1'b1;
   assign coef       = regs_ff;

endmodule

### hdl/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl: item sequencer
// Accepts an item, steps the micro-program, emits the result at block end.
// ----------------------------------------------------------------------------
module slm_ctrl
   import slm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.load     = 1'b0;
      cmd.emit     = 1'b0;
      cmd.uop      = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.uop = uop_rom(step_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(N_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!status.block_done) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/slm_dp.sv
// ----------------------------------------------------------------------------
// slm_dp: shared-multiplier datapath
// Filter state, block accumulators, peak holds and the result register.
// ----------------------------------------------------------------------------
module slm_dp
   import slm_pkg::*;
#(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
   parameter int MAX_BLOCK   = MAX_BLOCK_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  req_item_type  req_data,
   input  coef_bank_type coef,
   output dp_status_type status,
   output rsp_item_type  rsp_data
);

   localparam int SW = SAMPLE_BITS;
   localparam int ZW = 58;
   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam longint unsigned ALPHA_NUM = longint'(SAMPLE_RATE) << 40;
   localparam longint unsigned ALPHA_DEN = (longint'(SAMPLE_RATE) << 10) + TWO_PI_150_Q10;
   localparam logic [31:0] ALPHA = 32'(ALPHA_NUM / ALPHA_DEN);
   localparam logic signed [58:0] RND = 59'(64'd1 << 29);
   localparam logic signed [28:0] SMAX = 29'((64'sd1 <<< (SW - 1)) - 1);
   localparam logic signed [28:0] SMIN = 29'(-(64'sd1 <<< (SW - 1)));

   function automatic logic signed [SW-1:0] sat_round(input logic signed [58:0] v);
      logic signed [28:0] sh;
      sh = 29'(v >>> 30);
      if (sh > SMAX) return SW'(SMAX);
      if (sh < SMIN) return SW'(SMIN);
      return SW'(sh);
   endfunction

   // item and per-step working registers
   logic signed [SW-1:0] x_ff [2], x_in [2];
   logic                 end_ff, end_in;
   logic signed [SW-1:0] h_ff [2], h_in [2];
   logic signed [SW-1:0] k_ff [2], k_in [2];
   logic signed [ZW-1:0] t_ff, t_in, u_ff, u_in, v_ff, v_in;
   logic signed [57:0]   prod_ff;

   // filter history
   logic signed [ZW-1:0] zh0_ff [2], zh0_in [2], zh1_ff [2], zh1_in [2];
   logic signed [ZW-1:0] zs0_ff [2], zs0_in [2], zs1_ff [2], zs1_in [2];
   logic signed [SW-1:0] hp_ff [2], hp_in [2];
   logic signed [SW-1:0] oplast_ff [2], oplast_in [2];
   logic signed [SW-1:0] tplast_ff [2], tplast_in [2];
   logic signed [SW:0]   lastmono_ff, lastmono_in;

   // block totals
   logic [59:0] akw_ff, akw_in;
   logic [58:0] al_ff, al_in, ar_ff, ar_in, ahl_ff, ahl_in, ahr_ff, ahr_in;
   logic [59:0] ax_ff, ax_in;
   logic [60:0] amid_ff, amid_in, aside_ff, aside_in;
   logic [37:0] atr_ff, atr_in;
   logic [23:0] speak_ff, speak_in, tpeak_ff, tpeak_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic signed [31:0]   opa;
   logic signed [25:0]   opb;
   logic signed [25:0]   opd [2];
   logic signed [SW:0]   ssum, sdif;
   logic                 mc, ac;
   logic signed [ZW+1:0] zt;
   logic [23:0]          ml, mr, tpk;
   logic signed [25:0]   tdif;
   logic [25:0]          tmag;
   logic signed [27:0]   tpv;
   logic [27:0]          tpm;
   logic [23:0]          tpa;
   rsp_item_type         rsp_ff;

   assign mc   = cmd.uop.mul_ch;
   assign ac   = cmd.uop.act_ch;
   assign ssum = (SW+1)'(x_ff[0]) + (SW+1)'(x_ff[1]);
   assign sdif = (SW+1)'(x_ff[0]) - (SW+1)'(x_ff[1]);
   assign opd[0] = 26'(hp_ff[0]) + 26'(x_ff[0]) - 26'(oplast_ff[0]);
   assign opd[1] = 26'(hp_ff[1]) + 26'(x_ff[1]) - 26'(oplast_ff[1]);

   always_comb begin
      opa = '0;
      case (cmd.uop.a_sel)
         A_HB0:   opa = coef[REG_HP_B0];
         A_HA1:   opa = coef[REG_HP_A1];
         A_HA2:   opa = coef[REG_HP_A2];
         A_SB0:   opa = coef[REG_SHELF_B0];
         A_SB1:   opa = coef[REG_SHELF_B1];
         A_SB2:   opa = coef[REG_SHELF_B2];
         A_SA1:   opa = coef[REG_SHELF_A1];
         A_SA2:   opa = coef[REG_SHELF_A2];
         A_ALPHA: opa = ALPHA;
         A_X:     opa = 32'(x_ff[mc]);
         A_K:     opa = 32'(k_ff[mc]);
         A_HP:    opa = 32'(hp_ff[mc]);
         A_SUM:   opa = 32'(ssum);
         A_DIF:   opa = 32'(sdif);
         default: opa = '0;
      endcase
      case (cmd.uop.b_sel)
         B_X:     opb = 26'(x_ff[mc]);
         B_H:     opb = 26'(h_ff[mc]);
         B_K:     opb = 26'(k_ff[mc]);
         B_OPD:   opb = opd[mc];
         B_HP:    opb = 26'(hp_ff[mc]);
         B_HPR:   opb = 26'(hp_ff[1]);
         B_SUM:   opb = 26'(ssum);
         default: opb = 26'(sdif);
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
   end

   // magnitudes for peaks, true-peak interpolation, transient
   always_comb begin
      ml   = x_ff[0][SW-1] ? 24'(-x_ff[0]) : 24'(x_ff[0]);
      mr   = x_ff[1][SW-1] ? 24'(-x_ff[1]) : 24'(x_ff[1]);
      tdif = 26'(ssum) - 26'(lastmono_ff);
      tmag = tdif[25] ? 26'(-tdif) : 26'(tdif);
      tpk  = tpeak_ff;
      for (int k = 1; k <= 4; k++) begin
         tpv = (28'(tplast_ff[ac]) <<< 2)
             + (28'(x_ff[ac]) - 28'(tplast_ff[ac])) * 28'(k);
         tpm = tpv[27] ? 28'(-tpv) : 28'(tpv);
         tpa = 24'((tpm + 28'd2) >> 2);
         if (tpa > tpk) tpk = tpa;
      end
   end

   always_comb begin
      x_in = x_ff;  end_in = end_ff;  h_in = h_ff;  k_in = k_ff;
      t_in = t_ff;  u_in = u_ff;  v_in = v_ff;
      zh0_in = zh0_ff;  zh1_in = zh1_ff;  zs0_in = zs0_ff;  zs1_in = zs1_ff;
      hp_in = hp_ff;  oplast_in = oplast_ff;  tplast_in = tplast_ff;
      lastmono_in = lastmono_ff;
      akw_in = akw_ff;  al_in = al_ff;  ar_in = ar_ff;  ahl_in = ahl_ff;
      ahr_in = ahr_ff;  ax_in = ax_ff;  amid_in = amid_ff;  aside_in = aside_ff;
      atr_in = atr_ff;  speak_in = speak_ff;  tpeak_in = tpeak_ff;  cnt_in = cnt_ff;
      zt = '0;

      if (cmd.load) begin
         x_in[0] = req_data.left_sample;
         x_in[1] = req_data.right_sample;
         end_in  = req_data.block_end;
      end

      case (cmd.uop.act)
         ACT_HY: begin
            h_in[ac] = sat_round(59'(prod_ff) + 59'(zh0_ff[ac]) + RND);
            t_in     = prod_ff;
         end
         ACT_HZ0: begin
            // b1 = -2*b0, so b1*x is minus twice the saved b0*x
            zt = -((ZW+2)'(t_ff) <<< 1) - (ZW+2)'(prod_ff) + (ZW+2)'(zh1_ff[ac]);
            zh0_in[ac] = ZW'(zt);
         end
         ACT_HZ1: zh1_in[ac] = t_ff - ZW'(prod_ff);
         ACT_KY:  k_in[ac] = sat_round(59'(prod_ff) + 59'(zs0_ff[ac]) + RND);
         ACT_U:   u_in = prod_ff;
         ACT_V:   v_in = prod_ff;
         ACT_SZ0: begin
            zt = (ZW+2)'(u_ff) - (ZW+2)'(prod_ff) + (ZW+2)'(zs1_ff[ac]);
            zs0_in[ac] = ZW'(zt);
         end
         ACT_SZ1: zs1_in[ac] = v_ff - ZW'(prod_ff);
         ACT_OP: begin
            hp_in[ac]     = sat_round(59'(prod_ff) + RND);
            oplast_in[ac] = x_ff[ac];
         end
         ACT_ACC: begin
            case (cmd.uop.acc_idx)
               ACC_KW:  akw_in   = akw_ff + 60'(prod_ff);
               ACC_L:   al_in    = al_ff + 59'(prod_ff);
               ACC_R:   ar_in    = ar_ff + 59'(prod_ff);
               ACC_HL:  ahl_in   = ahl_ff + 59'(prod_ff);
               ACC_HR:  ahr_in   = ahr_ff + 59'(prod_ff);
               ACC_X:   ax_in    = ax_ff + 60'(prod_ff);
               ACC_MID: amid_in  = amid_ff + 61'(prod_ff);
               default: aside_in = aside_ff + 61'(prod_ff);
            endcase
         end
         ACT_TP: begin
            tpeak_in      = tpk;
            tplast_in[ac] = x_ff[ac];
         end
         ACT_PK: begin
            if (ml > speak_in) speak_in = ml;
            if (mr > speak_in) speak_in = mr;
            atr_in      = atr_ff + 38'(tmag);
            lastmono_in = ssum;
            cnt_in      = cnt_ff + 1'b1;
         end
         default: ;
      endcase

      if (cmd.emit) begin
         akw_in = '0;  al_in = '0;  ar_in = '0;  ahl_in = '0;  ahr_in = '0;
         ax_in = '0;  amid_in = '0;  aside_in = '0;  atr_in = '0;
         speak_in = '0;  tpeak_in = '0;  lastmono_in = '0;  cnt_in = '0;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      x_ff <= x_in;  end_ff <= end_in;  h_ff <= h_in;  k_ff <= k_in;
      t_ff <= t_in;  u_ff <= u_in;  v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zh0_ff <= '{default: '0};  zh1_ff <= '{default: '0};
         zs0_ff <= '{default: '0};  zs1_ff <= '{default: '0};
         hp_ff <= '{default: '0};  oplast_ff <= '{default: '0};
         tplast_ff <= '{default: '0};  lastmono_ff <= '0;
         akw_ff <= '0;  al_ff <= '0;  ar_ff <= '0;  ahl_ff <= '0;  ahr_ff <= '0;
         ax_ff <= '0;  amid_ff <= '0;  aside_ff <= '0;  atr_ff <= '0;
         speak_ff <= '0;  tpeak_ff <= '0;  cnt_ff <= '0;
      end else begin
         zh0_ff <= zh0_in;  zh1_ff <= zh1_in;  zs0_ff <= zs0_in;  zs1_ff <= zs1_in;
         hp_ff <= hp_in;  oplast_ff <= oplast_in;  tplast_ff <= tplast_in;
         lastmono_ff <= lastmono_in;
         akw_ff <= akw_in;  al_ff <= al_in;  ar_ff <= ar_in;  ahl_ff <= ahl_in;
         ahr_ff <= ahr_in;  ax_ff <= ax_in;  amid_ff <= amid_in;
         aside_ff <= aside_in;  atr_ff <= atr_in;
         speak_ff <= speak_in;  tpeak_ff <= tpeak_in;  cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.kweighted_sum   <= akw_ff[59:1];
         rsp_ff.left_energy     <= al_ff;
         rsp_ff.right_energy    <= ar_ff;
         rsp_ff.hp_left_energy  <= ahl_ff;
         rsp_ff.hp_right_energy <= ahr_ff;
         rsp_ff.hp_cross_sum    <= ax_ff;
         rsp_ff.mid_energy      <= amid_ff[60:2];
         rsp_ff.side_energy     <= aside_ff[60:2];
         rsp_ff.sample_peak     <= speak_ff;
         rsp_ff.true_peak       <= tpeak_ff;
         rsp_ff.transient_sum   <= atr_ff[37:1];
         rsp_ff.block_samples   <= 13'(cnt_ff);
      end
   end

   assign status.block_done = end_ff || (cnt_ff == CW'(MAX_BLOCK));
   assign rsp_data          = rsp_ff;

endmodule

### hdl/stereo_loudness_meter_accumulator_unit.sv
// ----------------------------------------------------------------------------
// stereo_loudness_meter_accumulator_unit: K-weighted stereo block meter
// Filters stereo samples and accumulates per-block energy and peak totals.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stereo sample item (left, right, block_end); it is taken
//   when req_valid is high and req_stall low. rsp_* delivers one totals item
//   per analysis block, after the item flagged block_end or after MAX_BLOCK
//   items, whichever comes first.
//   csr_* is an APB-style port for the eight Q2.30 coefficients at 4*i.
// Sequencing: each item passes an accept state, 32 micro-program steps and
//   a wrap-up state; req_stall stays high until the item is through. All 27
//   products of an item go through a single registered 32x26 multiplier,
//   one per step. The totals item is registered from the wrap-up state.
// Stall: a waiting result sits in the output register while the next items
//   are taken; only the end of the following block waits for it to drain.
// Reset: synchronous; filter history, totals and counter clear, the two b0
//   coefficients return to 1.0 and the rest to 0 (the shelf filter passes).
// ----------------------------------------------------------------------------
module stereo_loudness_meter_accumulator_unit
   import slm_pkg::*;
#(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
   parameter int MAX_BLOCK   = MAX_BLOCK_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_item_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_item_type      rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   coef_bank_type coef;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // coefficient bank; the user writes only while idle (bank does not enforce)
   slm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // sequencer: accept, step program, emit
   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // filters, accumulators and result register
   slm_dp #(
      .SAMPLE_RATE (SAMPLE_RATE),
      .MAX_BLOCK   (MAX_BLOCK)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .coef     (coef),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
